FILE: sv/tpem_pkg.sv
// Package: shared constants, opcodes and controller/datapath interface types.
package tpem_pkg;
  localparam int MaxNodes = 64;
  localparam int NodeW = 6;
  localparam int MaskW = 63;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic load;      // capture input item
    logic clr_step;  // clear one neighbour row
    logic add_rd;    // read row b while row a is captured
    logic add_a;     // or bit b into row a, write edge table
    logic add_b;     // or bit a into row b
    logic bfs_init;
    logic bfs_pop;   // read next queued node
    logic bfs_fetch; // latch popped node, read its row
    logic bfs_scan;  // process one neighbour candidate
    logic walk_rd;   // start edge table read for current node
    logic walk_acc;  // accumulate edge bit, step to parent
    logic res_zero;  // result: mask 0, reach from status
    logic res_load;  // result: accumulated mask, reach 1
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic equal;
    logic clr_done;
    logic q_empty;
    logic at_goal;
    logic scan_done;
    logic goal_seen;
    logic at_root;
  } sts_t;
endpackage

FILE: sv/tpem_ram.sv
// Generic single-port RAM with registered read.
module tpem_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: sv/tpem_ctrl.sv
// Controller: sequences clear, add, search and walk-back.
module tpem_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_free,
  input  tpem_pkg::sts_t sts,
  output tpem_pkg::cmd_t cmd,
  output logic          busy
);
  import tpem_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DEC  = 12'b000000000010,
    S_CLR  = 12'b000000000100,
    S_ADDA = 12'b000000001000,
    S_ADDB = 12'b000000010000,
    S_POP  = 12'b000000100000,
    S_POPW = 12'b000001000000,
    S_SCAN = 12'b000010000000,
    S_WRD  = 12'b000100000000,
    S_WPAR = 12'b001000000000,
    S_WACC = 12'b010000000000,
    S_RES  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   hit, hit_next;

  // reset enters the clearing pass over all neighbour rows
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    hit_next = hit;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          OP_CLEAR: state_next = S_CLR;
          OP_ADD: begin
            if (sts.in_range) begin
              cmd.add_rd = 1'b1;
              state_next = S_ADDA;
            end else state_next = S_IDLE;
          end
          OP_QUERY: begin
            if (!sts.in_range) begin
              hit_next = 1'b0;
              state_next = S_RES;
            end else if (sts.equal) begin
              hit_next = 1'b1;
              state_next = S_RES;
            end else begin
              cmd.bfs_init = 1'b1;
              state_next = S_POP;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_ADDA: begin
        cmd.add_a = 1'b1;
        state_next = S_ADDB;
      end
      S_ADDB: begin
        cmd.add_b = 1'b1;
        state_next = S_IDLE;
      end
      S_POP: begin
        if (sts.q_empty || sts.at_goal) begin
          if (sts.goal_seen) state_next = S_WRD;
          else begin
            hit_next = 1'b0;
            state_next = S_RES;
          end
        end else begin
          cmd.bfs_pop = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cmd.bfs_fetch = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.bfs_scan = 1'b1;
        if (sts.scan_done) state_next = S_POP;
      end
      S_WRD: begin
        if (sts.at_root) begin
          hit_next = 1'b1;
          state_next = S_RES;
        end else state_next = S_WPAR;
      end
      S_WPAR: begin
        cmd.walk_rd = 1'b1;
        state_next = S_WACC;
      end
      S_WACC: begin
        cmd.walk_acc = 1'b1;
        state_next = S_WRD;
      end
      S_RES: begin
        if (out_free) begin
          if (hit && sts.goal_seen && !sts.equal) cmd.res_load = 1'b1;
          else cmd.res_zero = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: sv/tpem_dp.sv
// Datapath: neighbour rows, edge table, parents, queue and path mask.
module tpem_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tpem_pkg::cmd_t                cmd,
  input  logic [1:0]                    in_op,
  input  logic [tpem_pkg::NodeW-1:0]    in_a,
  input  logic [tpem_pkg::NodeW-1:0]    in_b,
  input  logic [tpem_pkg::NodeW-1:0]    in_num,
  input  logic                          hit,
  output tpem_pkg::sts_t                sts,
  output logic [tpem_pkg::MaskW-1:0]    res_mask,
  output logic                          res_reach
);
  import tpem_pkg::*;

  logic [1:0]       op_q;
  logic [NodeW-1:0] a_q, b_q, num_q;
  logic [NodeW-1:0] clr_idx;
  logic [MaxNodes-1:0] visited, row;
  logic [NodeW:0]   head, tail;
  logic [NodeW-1:0] cur_u, scan_v, walk_cur, walk_par;
  logic [MaskW-1:0] acc;
  logic             new_v;

  // neighbour rows
  logic             nb_we;
  logic [NodeW-1:0] nb_addr;
  logic [MaxNodes-1:0] nb_wdata, nb_rdata;
  // edge table
  logic             et_we;
  logic [2*NodeW-1:0] et_addr;
  logic [NodeW-1:0] et_rdata;
  logic [NodeW-1:0] lo, hi;
  // search queue
  logic             q_we;
  logic [NodeW-1:0] q_addr, q_wdata, q_rdata;
  // parents
  logic             par_we;
  logic [NodeW-1:0] par_addr, par_rdata;

  always_comb begin
    nb_we = cmd.clr_step || cmd.add_a || cmd.add_b;
    nb_addr = cur_u;
    nb_wdata = '0;
    if (cmd.clr_step) nb_addr = clr_idx;
    else if (cmd.add_rd) nb_addr = b_q;
    else if (cmd.add_a) begin
      nb_addr = a_q;
      nb_wdata = row | (MaxNodes'(1) << b_q);
    end else if (cmd.add_b) begin
      nb_addr = b_q;
      nb_wdata = row | (MaxNodes'(1) << a_q);
    end else if (cmd.load) nb_addr = in_a;
    else if (cmd.bfs_fetch) nb_addr = q_rdata;
  end

  // row a is read at load, row b during add_rd; row is a registered copy of the read port
  tpem_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_nb (
    .clk(clk), .we(nb_we), .addr(nb_addr), .wdata(nb_wdata), .rdata(nb_rdata)
  );

  assign walk_par = par_rdata;
  assign lo = (walk_par < walk_cur) ? walk_par : walk_cur;
  assign hi = (walk_par < walk_cur) ? walk_cur : walk_par;
  always_comb begin
    et_we = cmd.add_a;
    et_addr = '0;
    if (cmd.add_a) et_addr = (a_q < b_q) ? {a_q, b_q} : {b_q, a_q};
    else if (cmd.walk_rd) et_addr = {lo, hi};
  end
  tpem_ram #(.Width(NodeW), .Depth(MaxNodes*MaxNodes)) u_et (
    .clk(clk), .we(et_we), .addr(et_addr), .wdata(num_q), .rdata(et_rdata)
  );

  // scan reads the row straight from the port, which holds row cur_u
  assign new_v = cmd.bfs_scan && nb_rdata[scan_v] && !visited[scan_v];

  always_comb begin
    q_we = cmd.bfs_init || (new_v && !tail[NodeW]);
    q_addr = head[NodeW-1:0];
    q_wdata = scan_v;
    if (cmd.bfs_init) begin
      q_addr = '0;
      q_wdata = a_q;
    end else if (cmd.bfs_scan) q_addr = tail[NodeW-1:0];
  end
  tpem_ram #(.Width(NodeW), .Depth(MaxNodes)) u_q (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
  );

  assign par_we = new_v;
  assign par_addr = cmd.bfs_scan ? scan_v : walk_cur;
  tpem_ram #(.Width(NodeW), .Depth(MaxNodes)) u_par (
    .clk(clk), .we(par_we), .addr(par_addr), .wdata(cur_u), .rdata(par_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_op; a_q <= in_a; b_q <= in_b; num_q <= in_num;
    end
    row <= nb_rdata;
    if (rst) clr_idx <= '0;
    else if (cmd.load) clr_idx <= '0;
    else if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
    if (cmd.bfs_init) begin
      visited <= MaxNodes'(1) << a_q;
      head <= '0;
      tail <= (NodeW+1)'(1);
      walk_cur <= b_q;
      acc <= '0;
    end
    if (cmd.bfs_pop) begin
      head <= head + 1'b1;
      scan_v <= '0;
    end
    if (cmd.bfs_fetch) cur_u <= q_rdata;
    if (cmd.bfs_scan) begin
      if (new_v) begin
        visited[scan_v] <= 1'b1;
        if (!tail[NodeW]) tail <= tail + 1'b1;
      end
      scan_v <= scan_v + 1'b1;
    end
    if (cmd.walk_acc) begin
      if (et_rdata != NodeW'(MaskW)) acc[et_rdata] <= 1'b1;
      walk_cur <= walk_par;
    end
    if (cmd.res_load) begin
      res_mask <= acc; res_reach <= 1'b1;
    end else if (cmd.res_zero) begin
      res_mask <= '0; res_reach <= hit;
    end
  end

  assign sts.op        = op_t'(op_q);
  assign sts.in_range  = 1'b1;
  assign sts.equal     = (a_q == b_q);
  assign sts.clr_done  = (clr_idx == NodeW'(MaxNodes-1));
  assign sts.q_empty   = (head == tail);
  assign sts.at_goal   = (head != '0) && (cur_u == b_q) && !cmd.bfs_scan;
  assign sts.scan_done = (scan_v == NodeW'(MaxNodes-1));
  assign sts.goal_seen = visited[b_q];
  assign sts.at_root   = (walk_cur == a_q);
endmodule

FILE: sv/tree_path_edge_mask.sv
// Top level: tree path edge-mask engine with stream ports.
// Holds a tree of up to 64 nodes as neighbour rows (64x64 RAM) and a 4096-entry
// edge-number RAM. After reset a clearing pass zeroes the rows, with s_tready
// low. op 0 clears the same way (decode, then one row per cycle), op 1 adds an
// edge. op 2 queries a path: an init step, then per dequeued node a pop, a row
// fetch and a scan of 64 neighbour candidates, and a step to end the search,
// then a walk back per path edge (parent read, edge RAM read, accumulate) plus a
// final root check, and a step to load the result; a query from a node to
// itself goes straight to the result. The result cycle waits while the output
// register still holds an item nobody has taken.
// One item at a time; s_tready is high only while idle.
module tree_path_edge_mask (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // op[1:0], node_a[7:2], node_b[13:8], edge_number[19:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // path_mask[62:0], reachable[63]
);
  import tpem_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy, hit;
  logic [MaskW-1:0] res_mask;
  logic res_reach;
  logic in_fire;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  // reach flag is carried by the result command pair
  assign hit = sts.equal && sts.in_range;

  tpem_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_tvalid || m_tready),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  tpem_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(s_tdata[1:0]), .in_a(s_tdata[7:2]),
    .in_b(s_tdata[13:8]), .in_num(s_tdata[19:14]), .hit(hit), .sts(sts),
    .res_mask(res_mask), .res_reach(res_reach)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.res_load || cmd.res_zero) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  assign m_tdata = {res_reach, res_mask};
endmodule

FILE: verif/tb_top.sv
// Testbench for tree_path_edge_mask: queued stimulus, clocked driver and monitor, path predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tpem_pkg::*;

  // Generous: one deep search visits up to 64 nodes, plus output stalls.
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 5000;
  localparam int TargetItems = 1800;

  typedef struct packed {
    logic [5:0] edge_num;
    logic [5:0] node_b;
    logic [5:0] node_a;
    op_t        op;
  } cmd_item_t;

  typedef struct packed {
    logic        reach;
    logic [62:0] mask;
  } path_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // op[1:0], node_a[7:2], node_b[13:8], edge_number[19:14]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // path_mask[62:0], reachable[63]

  tree_path_edge_mask DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  cmd_item_t pending_cmds[$];
  path_res_t expected_paths[$];
  int        errors = 0;
  int        sent_count = 0;
  int        idle_cycles = 0;

  // Shadow copy of the tree held by the block.
  logic [63:0] adj_rows[64];
  logic [5:0]  edge_ids[4096];

  // Breadth-first search from start, then walk parents back from goal.
  function automatic path_res_t find_path(logic [5:0] start, logic [5:0] goal);
    path_res_t   r;
    int          parent[64];
    logic [63:0] seen;
    int          bfs_q[64];
    int          head, tail, u, cur, p, lo, hi, num;
    r = '0;
    head = 0;
    tail = 0;
    for (int i = 0; i < 64; i++) parent[i] = 64;
    seen = 64'd1 << start;
    bfs_q[tail++] = start;
    while (head < tail) begin
      u = bfs_q[head & 63];
      head++;
      if (u == goal) break;
      // ascending order gives the first shortest path
      for (int v = 0; v < 64; v++) begin
        if (adj_rows[u][v] && !seen[v]) begin
          seen[v] = 1'b1;
          parent[v] = u;
          if (tail < 64) bfs_q[tail++] = v;
        end
      end
    end
    if (!seen[goal]) return r;
    r.reach = 1'b1;
    cur = goal;
    for (int s = 0; s < 64; s++) begin
      p = parent[cur];
      if (p >= 64) break;
      lo = (p < cur) ? p : cur;
      hi = (p < cur) ? cur : p;
      num = edge_ids[(lo << 6) | hi];
      if (num < 63) r.mask[num] = 1'b1;  // edge 63 has no bit
      cur = p;
    end
    return r;
  endfunction

  task automatic apply_cmd(cmd_item_t c);
    int lo, hi;
    case (c.op)
      OP_CLEAR: begin
        for (int i = 0; i < 64; i++) adj_rows[i] = '0;
      end
      OP_ADD: begin
        adj_rows[c.node_a][c.node_b] = 1'b1;
        adj_rows[c.node_b][c.node_a] = 1'b1;
        lo = (c.node_a < c.node_b) ? c.node_a : c.node_b;
        hi = (c.node_a < c.node_b) ? c.node_b : c.node_a;
        edge_ids[(lo << 6) | hi] = c.edge_num;
      end
      OP_QUERY: expected_paths = {expected_paths, find_path(c.node_a, c.node_b)};
      default: ;
    endcase
  endtask

  function automatic cmd_item_t mk(op_t op, int a, int b, int n);
    cmd_item_t c;
    c.op = op;
    c.node_a = a[5:0];
    c.node_b = b[5:0];
    c.edge_num = n[5:0];
    return c;
  endfunction

  task automatic queue_cmd(cmd_item_t c);
    pending_cmds = {pending_cmds, c};
  endtask

  // Idle rates by phase: sender/receiver 22/50, then 50/22, then none.
  function automatic int send_idle_pct();
    if (sent_count < TargetItems / 3) return 22;
    if (sent_count < 2 * TargetItems / 3) return 50;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent_count < TargetItems / 3) return 50;
    if (sent_count < 2 * TargetItems / 3) return 22;
    return 0;
  endfunction

  // Driver: item held until accepted, then the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_cmd(pending_cmds.pop_front());
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, pending_cmds[0]};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, in-order compare.
  always @(posedge clk) begin
    path_res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct());
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_paths.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_paths.pop_front();
          if (got.mask !== want.mask) begin
            $display("%0t: path_mask exp %h got %h", $time, want.mask, got.mask);
            errors++;
          end
          if (got.reach !== want.reach) begin
            $display("%0t: reachable exp %b got %b", $time, want.reach, got.reach);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Random tree over n distinct labels, then queries on it.
  task automatic build_tree_and_query(int n);
    int labels[64];
    int t, j, a, b, nq;
    for (int i = 0; i < 64; i++) labels[i] = i;
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(i);
      t = labels[i]; labels[i] = labels[j]; labels[j] = t;
    end
    queue_cmd(mk(OP_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(63)));
    for (int i = 1; i < n; i++) begin
      j = $urandom_range(i - 1);
      if ($urandom_range(1)) queue_cmd(mk(OP_ADD, labels[i], labels[j], $urandom_range(63)));
      else queue_cmd(mk(OP_ADD, labels[j], labels[i], $urandom_range(63)));
      // occasional self loop, renumbered pair, extra cycle edge or ignored op
      case ($urandom_range(15))
        0: queue_cmd(mk(OP_ADD, labels[i], labels[i], $urandom_range(63)));
        1: queue_cmd(mk(OP_ADD, labels[i], labels[j], $urandom_range(63)));
        2: queue_cmd(mk(OP_ADD, labels[i], labels[$urandom_range(i)], $urandom_range(63)));
        3: queue_cmd(mk(OP_NONE, $urandom_range(63), $urandom_range(63),
                        $urandom_range(63)));
        default: ;
      endcase
    end
    nq = $urandom_range(6, 3);
    for (int q = 0; q < nq; q++) begin
      a = labels[$urandom_range(n - 1)];
      b = labels[$urandom_range(n - 1)];
      if ($urandom_range(9) == 0) b = $urandom_range(63);
      if ($urandom_range(19) == 0) a = b;
      queue_cmd(mk(OP_QUERY, a, b, $urandom_range(63)));
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    for (int i = 0; i < 4096; i++) edge_ids[i] = '0;
    rst = 1'b1;

    // Directed: extreme labels and numbers, self loop, edge 63, renumber, cycle, clear.
    queue_cmd(mk(OP_CLEAR, 63, 63, 63));
    queue_cmd(mk(OP_ADD, 0, 63, 0));
    queue_cmd(mk(OP_ADD, 63, 5, 62));
    queue_cmd(mk(OP_ADD, 5, 10, 63));
    queue_cmd(mk(OP_ADD, 7, 7, 3));
    queue_cmd(mk(OP_ADD, 7, 5, 1));
    queue_cmd(mk(OP_QUERY, 0, 10, 0));
    queue_cmd(mk(OP_QUERY, 10, 0, 63));
    queue_cmd(mk(OP_QUERY, 7, 0, 0));
    queue_cmd(mk(OP_QUERY, 0, 0, 0));
    queue_cmd(mk(OP_QUERY, 63, 63, 0));
    queue_cmd(mk(OP_QUERY, 0, 20, 0));
    queue_cmd(mk(OP_NONE, 63, 63, 63));
    queue_cmd(mk(OP_ADD, 63, 0, 40));
    queue_cmd(mk(OP_QUERY, 0, 5, 0));
    queue_cmd(mk(OP_ADD, 0, 5, 2));
    queue_cmd(mk(OP_QUERY, 0, 10, 0));
    queue_cmd(mk(OP_QUERY, 10, 63, 0));
    queue_cmd(mk(OP_CLEAR, 21, 42, 21));
    queue_cmd(mk(OP_QUERY, 0, 63, 0));
    queue_cmd(mk(OP_ADD, 63, 0, 62));
    queue_cmd(mk(OP_QUERY, 63, 0, 0));

    // Random trees, mostly small to keep searches short, a few of 40 to 64 nodes.
    while (pending_cmds.size() < TargetItems) begin
      if ($urandom_range(11) == 0) build_tree_and_query($urandom_range(64, 40));
      else build_tree_and_query($urandom_range(10, 2));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && expected_paths.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_paths.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
